// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the search core modules.
// Depends on nothing; the assertion bodies vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked property, ignored while reset is asserted
`define NCS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ncs assertion failed");

// Clocked property that also holds through reset
`define NCS_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("ncs assertion failed");

`else

`define NCS_ASSERT(label, clk, rst_n, prop)

`define NCS_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ===== rtl/core/ncs_pkg.sv =====
// Shared types, constants and helper functions for the NAND circuit search core.
// No dependencies; imported by every module of the block except ncs_ram.
package ncs_pkg;

    // Fixed field widths and limits
    localparam int MAX_INPUTS    = 4;
    localparam int MAX_GATES_DEF = 6;
    localparam int WORD_W        = 16;
    localparam int SRC_W         = 4;
    localparam int GATE_W        = 2 * SRC_W;
    localparam int CAND_W        = 48;
    localparam int USED_W        = 3;
    localparam int NIN_W         = 3;
    localparam int LIM_W         = 3;
    localparam int IN_TDATA_W    = 8;
    localparam int OUT_TDATA_W   = 56;
    localparam int OUT_TUSER_W   = 2;
    localparam int CFG_IDX_W     = 4;
    localparam int CFG_DATA_W    = 16;

    // Configuration reset values
    localparam logic [WORD_W-1:0] TARGET_RST = 16'h0000;
    localparam logic [WORD_W-1:0] CARE_RST   = 16'hFFFF;
    localparam logic [NIN_W-1:0]  INPUTS_RST = 3'd2;
    localparam logic [LIM_W-1:0]  LIMIT_RST  = 3'd6;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET = 4'd0,
        REG_CARE   = 4'd1,
        REG_INPUTS = 4'd2,
        REG_LIMIT  = 4'd3
    } cfg_reg_t;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_READ,
        S_CALC,
        S_FINISH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic start;
        logic rd;
        logic calc;
        logic finish;
    } ncs_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic finished;
        logic no_gates;
        logic last_gate;
        logic out_full;
    } ncs_status_t;

    // Clamp the programmed input count into 1..MAX_INPUTS
    function automatic logic [NIN_W-1:0] eff_inputs(input logic [NIN_W-1:0] ic);
        logic [NIN_W-1:0] n;
        if (ic == '0)
            n = NIN_W'(1);
        else if (ic > NIN_W'(MAX_INPUTS))
            n = NIN_W'(MAX_INPUTS);
        else
            n = ic;
        return n;
    endfunction

    // Valid truth table rows for n inputs
    function automatic logic [WORD_W-1:0] row_mask(input logic [NIN_W-1:0] n);
        logic [WORD_W-1:0] m;
        unique case (n)
            3'd1:    m = 16'h0003;
            3'd2:    m = 16'h000F;
            3'd3:    m = 16'h00FF;
            default: m = 16'hFFFF;
        endcase
        return m;
    endfunction

    // Bit-parallel value of input i over all rows; input 0 is the row's top bit
    function automatic logic [WORD_W-1:0] input_word(input logic [NIN_W-1:0] n,
                                                     input logic [NIN_W-1:0] i);
        logic [WORD_W-1:0] w;
        logic [NIN_W-1:0]  p;
        logic [3:0]        rv;
        w = '0;
        p = n - NIN_W'(1) - i;
        for (int r = 0; r < WORD_W; r++) begin
            rv   = 4'(r);
            w[r] = rv[p[1:0]];
        end
        return w & row_mask(n);
    endfunction

endpackage

// ===== rtl/core/ncs_ram.sv =====
// Generic simple RAM: one write port, two registered read ports.
// No dependencies.
module ncs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 6
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
    output logic [WIDTH-1:0]                       rdata_a,
    output logic [WIDTH-1:0]                       rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    // Write port and registered reads
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ===== rtl/core/ncs_ctrl.sv =====
// Sequencing state machine for the NAND circuit search core.
// Depends on ncs_pkg and assert_macros.svh; drives commands to ncs_dpath.
`include "assert_macros.svh"

module ncs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  ncs_pkg::ncs_status_t status,
    output ncs_pkg::ncs_cmd_t    cmd
);
    import ncs_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                // no test when the search is over; zero gates needs no evaluation
                if (status.finished || status.no_gates)
                    state_next = S_FINISH;
                else
                    state_next = S_READ;
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_CALC;
            end
            S_CALC:
            begin
                cmd.calc = 1'b1;
                if (status.last_gate)
                    state_next = S_FINISH;
                else
                    state_next = S_READ;
            end
            S_FINISH:
            begin
                if (!status.out_full)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Checks
    `NCS_ASSERT(a_read_then_calc, clk, rst_n, (state_reg == S_READ) |=> (state_reg == S_CALC))
    `NCS_ASSERT(a_finish_needs_room, clk, rst_n, cmd.finish |-> !status.out_full)
    `NCS_ASSERT_ALWAYS(a_one_cmd, clk, $onehot0({cmd.start, cmd.rd, cmd.calc, cmd.finish}))

endmodule

// ===== rtl/core/ncs_dpath.sv =====
// Datapath: configuration registers, candidate sources, gate evaluation,
// odometer advance and the output register. Depends on ncs_pkg, ncs_ram, assert_macros.svh.
`include "assert_macros.svh"

module ncs_dpath #(
    parameter int MAX_GATES = ncs_pkg::MAX_GATES_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [ncs_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [ncs_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  restart,
    input  ncs_pkg::ncs_cmd_t                     cmd,
    output ncs_pkg::ncs_status_t                  status,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [ncs_pkg::OUT_TDATA_W-1:0]       m_tdata,
    output logic [ncs_pkg::OUT_TUSER_W-1:0]       m_tuser,
    output logic                                  m_tlast
);
    import ncs_pkg::*;

    localparam int CW     = $clog2(MAX_GATES + 1);
    localparam int KW     = (MAX_GATES > 1) ? $clog2(MAX_GATES) : 1;
    localparam int PACK_N = (MAX_GATES < CAND_W / GATE_W) ? MAX_GATES : CAND_W / GATE_W;

    // Configuration
    logic [WORD_W-1:0] target_reg;
    logic [WORD_W-1:0] care_reg;
    logic [NIN_W-1:0]  inputs_reg;
    logic [LIM_W-1:0]  limit_reg;

    // Search state
    logic [GATE_W-1:0] src_reg  [MAX_GATES];
    logic [GATE_W-1:0] src_next [MAX_GATES];
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     k_reg, k_next;
    logic              found_reg, found_next;
    logic              finished_reg, finished_next;
    logic              failed_reg, failed_next;
    logic [WORD_W-1:0] last_word_reg, last_word_next;

    // Output register
    logic                   out_valid_reg, out_valid_next;
    logic [CAND_W-1:0]      out_cand_reg, out_cand_next;
    logic [USED_W-1:0]      out_used_reg, out_used_next;
    logic                   out_hit_reg, out_hit_next;
    logic                   out_over_reg, out_over_next;
    logic                   out_failed_reg, out_failed_next;

    // Evaluation signals
    logic [NIN_W-1:0]  n_eff;
    logic [WORD_W-1:0] rmask;
    logic [GATE_W-1:0] src_cur;
    logic [SRC_W-1:0]  src_a, src_b;
    logic [SRC_W-1:0]  off_a, off_b;
    logic [WORD_W-1:0] rd_a, rd_b;
    logic [WORD_W-1:0] op_a, op_b;
    logic [WORD_W-1:0] gate_word;
    logic [WORD_W-1:0] out_word;
    logic              hit;
    logic [LIM_W-1:0]  lim_eff;
    logic              over_limit;
    logic [CAND_W-1:0] cand;

    // Advance signals
    logic [SRC_W-1:0]     sig_m1 [MAX_GATES];
    logic [SRC_W-1:0]     b_lim  [MAX_GATES];
    logic [MAX_GATES-1:0] can_b;
    logic [MAX_GATES-1:0] inc_ok;
    logic [GATE_W-1:0]    inc_val [MAX_GATES];
    logic                 adv_ok;
    logic [KW-1:0]        adv_idx;

    assign n_eff = eff_inputs(inputs_reg);
    assign rmask = row_mask(n_eff);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= TARGET_RST;
            care_reg   <= CARE_RST;
            inputs_reg <= INPUTS_RST;
            limit_reg  <= LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_TARGET: target_reg <= cfg_data;
                REG_CARE:   care_reg   <= cfg_data;
                REG_INPUTS: inputs_reg <= cfg_data[NIN_W-1:0];
                REG_LIMIT:  limit_reg  <= cfg_data[LIM_W-1:0];
                default:    ;
            endcase
        end
    end

    // Gate operand fetch: inputs from the pattern function, earlier gates from RAM
    assign src_cur = src_reg[k_reg[KW-1:0]];
    assign src_a   = src_cur[SRC_W-1:0];
    assign src_b   = src_cur[GATE_W-1:SRC_W];
    assign off_a   = src_a - SRC_W'(n_eff);
    assign off_b   = src_b - SRC_W'(n_eff);

    ncs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_GATES)
    ) u_sig_ram (
        .clk     (clk),
        .we      (cmd.calc),
        .waddr   (k_reg[KW-1:0]),
        .wdata   (gate_word),
        .re      (cmd.rd),
        .raddr_a (off_a[KW-1:0]),
        .raddr_b (off_b[KW-1:0]),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    // A source not yet computed reads zero
    always_comb
    begin
        if (src_a < SRC_W'(n_eff))
            op_a = input_word(n_eff, src_a[NIN_W-1:0]);
        else if (off_a < SRC_W'(k_reg))
            op_a = rd_a;
        else
            op_a = '0;
        if (src_b < SRC_W'(n_eff))
            op_b = input_word(n_eff, src_b[NIN_W-1:0]);
        else if (off_b < SRC_W'(k_reg))
            op_b = rd_b;
        else
            op_b = '0;
    end

    assign gate_word = ~(op_a & op_b) & rmask;

    // Output signal compare against the cared rows
    assign out_word = (count_reg == '0) ? input_word(n_eff, n_eff - NIN_W'(1)) : last_word_reg;
    assign hit      = ((out_word ^ target_reg) & care_reg & rmask) == '0;

    // Odometer digit per gate: b counts up to min(a, s-1), then a steps and b clears
    always_comb
    begin
        for (int k = 0; k < MAX_GATES; k++)
        begin
            sig_m1[k] = SRC_W'(n_eff) + SRC_W'(k) - SRC_W'(1);
            b_lim[k]  = (src_reg[k][SRC_W-1:0] < sig_m1[k]) ? src_reg[k][SRC_W-1:0]
                                                            : sig_m1[k];
            can_b[k]  = src_reg[k][GATE_W-1:SRC_W] != b_lim[k];
            inc_ok[k] = (count_reg > CW'(k)) &&
                        (can_b[k] || (src_reg[k][SRC_W-1:0] != sig_m1[k]));
            if (can_b[k])
                inc_val[k] = {src_reg[k][GATE_W-1:SRC_W] + SRC_W'(1), src_reg[k][SRC_W-1:0]};
            else
                inc_val[k] = {{SRC_W{1'b0}}, src_reg[k][SRC_W-1:0] + SRC_W'(1)};
        end
    end

    // Highest gate that can still step
    always_comb
    begin
        adv_idx = '0;
        for (int k = 0; k < MAX_GATES; k++)
        begin
            if (inc_ok[k])
                adv_idx = KW'(k);
        end
    end

    assign adv_ok = |inc_ok;

    // Candidate packing, one byte per gate in use
    always_comb
    begin
        cand = '0;
        for (int k = 0; k < PACK_N; k++)
        begin
            if (count_reg > CW'(k))
                cand[GATE_W*k +: GATE_W] = src_reg[k];
        end
    end

    assign lim_eff    = (limit_reg > LIM_W'(MAX_GATES)) ? LIM_W'(MAX_GATES) : limit_reg;
    assign over_limit = ({1'b0, USED_W'(count_reg)} + 4'd1) > {1'b0, lim_eff};

    // Next state of the search
    always_comb
    begin
        src_next        = src_reg;
        count_next      = count_reg;
        k_next          = k_reg;
        found_next      = found_reg;
        finished_next   = finished_reg;
        failed_next     = failed_reg;
        last_word_next  = last_word_reg;
        out_valid_next  = out_valid_reg;
        out_cand_next   = out_cand_reg;
        out_used_next   = out_used_reg;
        out_hit_next    = out_hit_reg;
        out_over_next   = out_over_reg;
        out_failed_next = out_failed_reg;

        if (cmd.start)
        begin
            k_next = '0;
            if (restart)
            begin
                for (int j = 0; j < MAX_GATES; j++)
                    src_next[j] = '0;
                count_next    = '0;
                found_next    = 1'b0;
                finished_next = 1'b0;
                failed_next   = 1'b0;
            end
        end

        if (cmd.calc)
        begin
            last_word_next = gate_word;
            k_next         = k_reg + CW'(1);
        end

        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
            out_used_next  = USED_W'(count_reg);
            if (finished_reg)
            begin
                out_cand_next   = '0;
                out_hit_next    = 1'b0;
                out_over_next   = 1'b1;
                out_failed_next = failed_reg;
            end
            else
            begin
                out_cand_next = cand;
                out_hit_next  = hit;
                found_next    = found_reg | hit;
                if (adv_ok)
                begin
                    for (int j = 0; j < MAX_GATES; j++)
                    begin
                        if (j == int'(adv_idx))
                            src_next[j] = inc_val[j];
                        else if (j > int'(adv_idx))
                            src_next[j] = '0;
                    end
                end
                else if (found_reg | hit)
                begin
                    finished_next = 1'b1;
                end
                else if (over_limit)
                begin
                    finished_next = 1'b1;
                    failed_next   = 1'b1;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                    for (int j = 0; j < MAX_GATES; j++)
                        src_next[j] = '0;
                end
                out_over_next   = finished_next;
                out_failed_next = failed_next;
            end
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < MAX_GATES; j++)
                src_reg[j] <= '0;
            count_reg     <= '0;
            k_reg         <= '0;
            found_reg     <= 1'b0;
            finished_reg  <= 1'b0;
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            src_reg       <= src_next;
            count_reg     <= count_next;
            k_reg         <= k_next;
            found_reg     <= found_next;
            finished_reg  <= finished_next;
            failed_reg    <= failed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        last_word_reg  <= last_word_next;
        out_cand_reg   <= out_cand_next;
        out_used_reg   <= out_used_next;
        out_hit_reg    <= out_hit_next;
        out_over_reg   <= out_over_next;
        out_failed_reg <= out_failed_next;
    end

    // Status back to the controller
    assign status.finished  = finished_reg;
    assign status.no_gates  = count_reg == '0;
    assign status.last_gate = (k_reg + CW'(1)) == count_reg;
    assign status.out_full  = out_valid_reg && !m_tready;

    // Result channel
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - CAND_W - USED_W){1'b0}}, out_used_reg, out_cand_reg};
    assign m_tuser  = {out_failed_reg, out_hit_reg};
    assign m_tlast  = out_over_reg;

    // Checks
    `NCS_ASSERT(a_fail_is_final, clk, rst_n, failed_reg |-> finished_reg)
    `NCS_ASSERT(a_gate_idx_bound, clk, rst_n, k_reg <= count_reg)
    `NCS_ASSERT(a_done_holds, clk, rst_n, (finished_reg && !cmd.start) |=> finished_reg)

endmodule

// ===== rtl/core/nand_circuit_search.sv =====
// Top level of the exhaustive NAND circuit search block.
// Depends on ncs_pkg, ncs_ctrl and ncs_dpath.
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes target_table (0),
//   care_mask (1), input_count (2) and gate_limit (3); cfg_ready is always high and
//   writes are meant for an idle block.
//   Each transaction on the s_ channel (s_tdata[0] = restart) tests one candidate
//   NAND network and steps the odometer; it yields exactly one transaction on
//   the m_ channel with the candidate, its gate count, the match flag and the
//   end-of-search flags.
//   After an input is accepted, the core evaluates the candidate gate by gate, each
//   gate as a signal RAM read, then the NAND and write back; once the search is
//   over no gate is evaluated. The next input is taken in the cycle after the result
//   is loaded, so the core takes no new input before it is through with the last one.
//   Reset clears the configuration to its defaults and the search to zero gates.
//   If the receiver stalls, the result waits in the output register and the core
//   holds its next result until that register frees.
module nand_circuit_search #(
    parameter int MAX_GATES = ncs_pkg::MAX_GATES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // s_tdata: [0] restart, [7:1] zero
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [ncs_pkg::IN_TDATA_W-1:0]     s_tdata,
    // m_tdata: [47:0] candidate, [50:48] gates_used, [55:51] zero
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [ncs_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // m_tuser: [0] matched, [1] search_failed
    output logic [ncs_pkg::OUT_TUSER_W-1:0]    m_tuser,
    // m_tlast: search_over
    output logic                               m_tlast,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ncs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ncs_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import ncs_pkg::*;

    ncs_cmd_t    cmd;
    ncs_status_t status;
    logic        cfg_we;

    // Configuration is always accepted
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    ncs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ncs_dpath #(
        .MAX_GATES (MAX_GATES)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .restart   (s_tdata[0]),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== bench/nand_circuit_search_check.sv =====
`timescale 1ns / 1ps
// Checker for the NAND circuit search block: follows the config, input and result
// channels, predicts every result from its own copy of the odometer search and compares.
// Depends on ncs_pkg.
module nand_circuit_search_check #(
    parameter int MAX_GATES = ncs_pkg::MAX_GATES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [ncs_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [ncs_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic [ncs_pkg::OUT_TUSER_W-1:0] m_tuser,
    input  logic                            m_tlast,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [ncs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ncs_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              fail_count,
    output int                              results_seen,
    output int                              pending
);
    import ncs_pkg::*;

    typedef struct packed {
        logic [CAND_W-1:0] candidate;
        logic [USED_W-1:0] gates_used;
        logic              matched;
        logic              search_over;
        logic              search_failed;
    } search_result_t;

    // Shadow configuration
    logic [WORD_W-1:0] want_table;
    logic [WORD_W-1:0] care_rows;
    logic [NIN_W-1:0]  inputs_cfg;
    logic [LIM_W-1:0]  limit_cfg;

    // Shadow search state
    logic [GATE_W-1:0] gate_src [MAX_GATES];
    int                gate_cnt;
    bit                found_match;
    bit                search_done;
    bit                search_lost;

    search_result_t    expected_results [$];
    int                step_errs;

    function automatic int active_inputs();
        int n;
        if (inputs_cfg == '0)
            n = 1;
        else if (int'(inputs_cfg) > MAX_INPUTS)
            n = MAX_INPUTS;
        else
            n = int'(inputs_cfg);
        return n;
    endfunction

    function automatic void clear_gates();
        for (int k = 0; k < MAX_GATES; k++)
            gate_src[k] = '0;
    endfunction

    // Bit-parallel evaluation of the current network over all rows
    function automatic bit candidate_hits(input int n);
        logic [15:0] sig [16];
        logic [15:0] rmask;
        logic [15:0] diff;
        int          rows;
        int          a;
        int          b;
        int          s;
        int          o;
        rows  = 1 << n;
        rmask = (rows >= 16) ? 16'hFFFF : 16'((1 << rows) - 1);
        for (int i = 0; i < 16; i++)
            sig[i] = '0;
        // input 0 is the most significant bit of the row number
        for (int i = 0; i < n; i++)
            for (int r = 0; r < rows; r++)
                sig[i][r] = 1'((r >> (n - 1 - i)) & 1);
        // a source not yet computed reads zero
        for (int k = 0; k < gate_cnt && k < MAX_GATES; k++) begin
            s      = (n + k) & 15;
            a      = int'(gate_src[k][3:0]);
            b      = int'(gate_src[k][7:4]);
            sig[s] = ~(sig[a] & sig[b]) & rmask;
        end
        o    = (n + gate_cnt - 1) & 15;
        diff = (sig[o] ^ want_table) & care_rows & rmask;
        return diff == '0;
    endfunction

    // Step the odometer, last gate's second source fastest; 0 when exhausted
    function automatic bit step_odometer(input int n);
        int k;
        int s;
        int a;
        int b;
        int lim;
        bit moved;
        moved = 1'b0;
        k     = (gate_cnt > MAX_GATES) ? MAX_GATES : gate_cnt;
        while (k > 0 && !moved) begin
            k--;
            s   = n + k;
            a   = int'(gate_src[k][3:0]);
            b   = int'(gate_src[k][7:4]);
            lim = s - 1;
            if (a < lim)
                lim = a;
            if (b != lim) begin
                b     = (b + 1) & 15;
                moved = 1'b1;
            end
            else if (a != s - 1) begin
                a     = (a + 1) & 15;
                b     = 0;
                moved = 1'b1;
            end
            if (moved) begin
                gate_src[k] = {4'(b), 4'(a)};
                for (int j = k + 1; j < MAX_GATES; j++)
                    gate_src[j] = '0;
            end
        end
        return moved;
    endfunction

    // One search step: test the candidate, then advance
    task automatic predict_step(input logic restart, output search_result_t res);
        int          n;
        int          lim;
        logic [63:0] cand;
        bit          hit;
        n    = active_inputs();
        cand = '0;
        hit  = 1'b0;
        if (restart) begin
            clear_gates();
            gate_cnt    = 0;
            found_match = 1'b0;
            search_done = 1'b0;
            search_lost = 1'b0;
        end
        res.gates_used = USED_W'(gate_cnt);
        if (!search_done) begin
            for (int k = 0; k < gate_cnt && k < MAX_GATES; k++)
                cand[8*k +: 8] = gate_src[k];
            hit = candidate_hits(n);
            if (hit)
                found_match = 1'b1;
            if (!step_odometer(n)) begin
                lim = (int'(limit_cfg) > MAX_GATES) ? MAX_GATES : int'(limit_cfg);
                if (found_match)
                    search_done = 1'b1;
                else if (gate_cnt + 1 > lim) begin
                    search_done = 1'b1;
                    search_lost = 1'b1;
                end
                else begin
                    gate_cnt++;
                    clear_gates();
                end
            end
        end
        res.candidate     = cand[CAND_W-1:0];
        res.matched       = hit;
        res.search_over   = search_done;
        res.search_failed = search_lost;
    endtask

    task automatic report_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
        step_errs++;
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    endtask

    // Follow the three channels at every rising edge
    always @(posedge clk or negedge rst_n)
    begin : track
        search_result_t res;
        search_result_t got;
        search_result_t want;
        if (!rst_n) begin
            want_table  = TARGET_RST;
            care_rows   = CARE_RST;
            inputs_cfg  = INPUTS_RST;
            limit_cfg   = LIMIT_RST;
            clear_gates();
            gate_cnt    = 0;
            found_match = 1'b0;
            search_done = 1'b0;
            search_lost = 1'b0;
            expected_results.delete();
            fail_count   <= 0;
            results_seen <= 0;
            pending      <= 0;
        end
        else begin
            step_errs = 0;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_TARGET: want_table = cfg_data;
                    REG_CARE:   care_rows  = cfg_data;
                    REG_INPUTS: inputs_cfg = cfg_data[NIN_W-1:0];
                    REG_LIMIT:  limit_cfg  = cfg_data[LIM_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                predict_step(s_tdata[0], res);
                expected_results.push_back(res);
            end
            if (m_tvalid && m_tready) begin
                got.candidate     = m_tdata[CAND_W-1:0];
                got.gates_used    = m_tdata[CAND_W +: USED_W];
                got.matched       = m_tuser[0];
                got.search_over   = m_tlast;
                got.search_failed = m_tuser[1];
                if (expected_results.size() == 0) begin
                    step_errs++;
                    $display("%0t: result with nothing expected, actual %0h",
                             $time, got);
                end
                else begin
                    want = expected_results.pop_front();
                    if (want.candidate !== got.candidate)
                        report_field("candidate", 64'(want.candidate), 64'(got.candidate));
                    if (want.gates_used !== got.gates_used)
                        report_field("gates_used", 64'(want.gates_used),
                                     64'(got.gates_used));
                    if (want.matched !== got.matched)
                        report_field("matched", 64'(want.matched), 64'(got.matched));
                    if (want.search_over !== got.search_over)
                        report_field("search_over", 64'(want.search_over),
                                     64'(got.search_over));
                    if (want.search_failed !== got.search_failed)
                        report_field("search_failed", 64'(want.search_failed),
                                     64'(got.search_failed));
                end
                results_seen <= results_seen + 1;
            end
            fail_count <= fail_count + step_errs;
            pending    <= expected_results.size();
        end
    end

endmodule

// ===== bench/nand_circuit_search_tb.sv =====
`timescale 1ns / 1ps
// Top of the NAND circuit search bench: clock, reset, config writes and search steps,
// with random idling on both sides. Depends on ncs_pkg, the block and its checker.
module nand_circuit_search_tb;
    import ncs_pkg::*;

    localparam int GATES        = MAX_GATES_DEF;
    localparam int TOTAL_STEPS  = 1350;
    localparam int DRAIN_CYCLES = 3 + 2 * GATES + 8;
    localparam int LONG_HOLD    = 300;
    localparam int HOLD_PHASE   = 6;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;
    logic                   m_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int fail_count;
    int results_seen;
    int pending;
    int steps_sent;
    bit tx_idle;
    bit rx_idle;
    int hold_req;
    int hold_served;

    nand_circuit_search #(.MAX_GATES(GATES)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    nand_circuit_search_check #(.MAX_GATES(GATES)) search_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .results_seen (results_seen),
        .pending      (pending)
    );

    // 100 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #3_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Result side: random gaps, and one long hold when asked
    initial
    begin : rx_proc
        int gap;
        m_tready    = 1'b0;
        hold_served = 0;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (hold_served != hold_req) begin
                gap         = LONG_HOLD;
                hold_served = hold_req;
            end
            else
                gap = rx_idle ? $urandom_range(0, 7) : 0;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
        end
    end

    // One search step transaction
    task automatic send_step(input logic restart);
        int gap;
        gap = tx_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W-1){1'b0}}, restart};
        do @(posedge clk); while (!s_tready);
        steps_sent++;
    endtask

    task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic program_search(input logic [15:0] tgt, input logic [15:0] care,
                                  input logic [2:0] nin, input logic [2:0] lim);
        write_register(REG_TARGET, tgt);
        write_register(REG_CARE, care);
        write_register(REG_INPUTS, 16'(nin));
        write_register(REG_LIMIT, 16'(lim));
        cfg_valid <= 1'b0;
    endtask

    // Hold off until every step has its result back
    task automatic wait_drained();
        while (results_seen != steps_sent)
            @(posedge clk);
    endtask

    // Fixed restart pattern, bit 0 first
    task automatic run_pattern(input logic [7:0] bits, input int count);
        for (int i = 0; i < count; i++)
            send_step(bits[i]);
        s_tvalid <= 1'b0;
    endtask

    task automatic run_batch(input int count, input bit restart_first, input int odds);
        for (int i = 0; i < count; i++)
            send_step((i == 0) ? restart_first : ($urandom_range(0, odds - 1) == 0));
        s_tvalid <= 1'b0;
    endtask

    // Stimulus and verdict
    initial
    begin : main_proc
        int          phase;
        int          count;
        int          sel;
        logic [15:0] tgt;
        logic [15:0] care;
        logic [2:0]  nin;
        logic [2:0]  lim;

        s_tvalid   = 1'b0;
        s_tdata    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_TARGET;
        cfg_data   = '0;
        rst_n      = 1'b0;
        steps_sent = 0;
        hold_req   = 0;
        tx_idle    = 1'b1;
        rx_idle    = 1'b1;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: stepping from the cleared state, then a restart
        run_pattern(8'b0000_0100, 4);

        // Nothing cared: zero gates match at once, then idle steps after the end and a restart
        wait_drained();
        program_search(16'h0000, 16'h0000, 3'd0, 3'd0);
        run_pattern(8'b0000_1001, 5);

        // Zero gate limit with a miss: immediate failure
        wait_drained();
        program_search(16'h0001, 16'hFFFF, 3'd1, 3'd0);
        run_pattern(8'b0000_0001, 3);

        // Single inverter found at one gate
        wait_drained();
        program_search(16'h0001, 16'hFFFF, 3'd1, 3'd1);
        run_pattern(8'b0000_0001, 4);

        // Input count and gate limit above range
        wait_drained();
        program_search(16'hFFFF, 16'hFFFF, 3'd7, 3'd7);
        run_pattern(8'b0000_0001, 5);

        // Four inputs, parity target on alternate rows
        wait_drained();
        program_search(16'h6996, 16'hAAAA, 3'd4, 3'd6);
        run_pattern(8'b0000_0001, 4);

        // Random phases; config only changes while the block is drained
        phase = 0;
        while (steps_sent < TOTAL_STEPS) begin
            wait_drained();
            sel = $urandom_range(0, 7);
            tgt = (sel == 0) ? 16'h0000 : (sel == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
            sel = $urandom_range(0, 7);
            if (sel == 0)
                care = 16'h0000;
            else if (sel == 1)
                care = 16'hFFFF;
            else if (sel < 5)
                care = 16'($urandom) & 16'($urandom) & 16'($urandom);
            else
                care = 16'($urandom_range(0, 65535));
            sel = $urandom_range(0, 11);
            nin = (sel < 8) ? 3'(sel) : (sel < 10) ? 3'd1 : 3'd2;
            sel = $urandom_range(0, 11);
            lim = (sel < 8) ? 3'(sel) : 3'(sel - 8);
            program_search(tgt, care, nin, lim);

            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            // one phase keeps the sender busy behind a long result stall
            if (phase == HOLD_PHASE) begin
                hold_req++;
                count = 60;
            end
            else
                count = $urandom_range(10, 50);
            run_batch(count, $urandom_range(0, 3) != 0, 40);
            phase++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
